// ----- hdl/sha256_stream_hasher_defines.svh -----
// Assertion macros for the checker file of the SHA-256 stream hasher.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define SSH_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define SSH_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ssh_pkg.sv -----
// Package for the SHA-256 stream hasher: shared types, command/status structs,
// round constants and initial hash values. No dependencies.
`default_nettype none

package ssh_pkg;

  localparam int unsigned ROUNDS = 64;

  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam logic [5:0]  LEN_POS     = 6'd56;  // first byte slot of the length field
  localparam logic [5:0]  LAST_SLOT   = 6'd63;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [2:0]  LAST_WORD   = 3'd7;
  localparam logic [63:0] BLOCK_BITS  = 64'd512;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Source of the byte shifted into the block window.
  typedef enum logic [1:0] {
    BSRC_DATA,
    BSRC_MARK,
    BSRC_ZERO,
    BSRC_LEN
  } byte_src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic      byte_en;    // shift one byte into the window
    byte_src_t byte_sel;
    logic      len_add;    // a full message block was absorbed
    logic      total_load; // latch final bit length
    logic      rnd_init;   // load working vars from chain
    logic      rnd_step;   // run one compression round
    logic      chain_add;  // fold working vars into chain
    logic      word_step;  // advance digest output index
    logic      msg_clear;  // back to initial hash state
  } dp_cmd_t;

  typedef struct packed {
    logic fill_full;  // window holds 63 bytes
    logic fill_len;   // window holds 56 bytes
    logic round_last;
    logic word_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/ssh_stream_if.sv -----
// Valid/ready channel interfaces for the SHA-256 stream hasher:
// byte input channel and digest word output channel. No dependencies.
`default_nettype none

interface ssh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, data_byte, byte_present, last_byte, input ready);
  modport sink   (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface ssh_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ----- hdl/ssh_datapath.sv -----
// Datapath of the SHA-256 stream hasher: 512-bit block window with message
// schedule, round logic, chaining words and length counters. Uses ssh_pkg.
`default_nettype none

module ssh_datapath (
  input  logic                clk,
  input  logic                rst,
  input  ssh_pkg::dp_cmd_t    cmd,
  input  logic [7:0]          data_byte,
  output ssh_pkg::dp_status_t status,
  output logic [31:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last_word
);
  import ssh_pkg::*;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  logic [511:0] window;       // block bytes, oldest in the top bits
  logic [5:0]   fill;
  logic [63:0]  length_bits;
  logic [63:0]  total;        // final length, shifted out MSB first
  logic [31:0]  chain [8];
  logic [31:0]  work  [8];
  logic [5:0]   round;
  logic [2:0]   word_idx;

  logic [7:0]  new_byte;
  logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
  logic [31:0] big0, big1, choose, major, t1, t2;

  always_comb begin
    unique case (cmd.byte_sel)
      BSRC_DATA: new_byte = data_byte;
      BSRC_MARK: new_byte = PAD_MARK;
      BSRC_ZERO: new_byte = 8'h00;
      BSRC_LEN:  new_byte = total[63:56];
      default:   new_byte = 8'h00;
    endcase
  end

  // Schedule taps: window word i is W[t+i] during round t.
  assign w0  = window[511:480];
  assign w1  = window[479:448];
  assign w9  = window[223:192];
  assign w14 = window[63:32];
  assign s0  = ror32(w1, 7) ^ ror32(w1, 18) ^ (w1 >> 3);
  assign s1  = ror32(w14, 17) ^ ror32(w14, 19) ^ (w14 >> 10);
  assign w_new = s1 + w9 + s0 + w0;

  assign big1   = ror32(work[4], 6) ^ ror32(work[4], 11) ^ ror32(work[4], 25);
  assign choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign big0   = ror32(work[0], 2) ^ ror32(work[0], 13) ^ ror32(work[0], 22);
  assign major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1     = work[7] + big1 + choose + ROUND_K[round] + w0;
  assign t2     = big0 + major;

  // Control-side registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      length_bits <= '0;
      round       <= '0;
      word_idx    <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= START_H[i];
    end else begin
      if (cmd.byte_en) fill <= fill + 6'd1;
      if (cmd.len_add) length_bits <= length_bits + BLOCK_BITS;
      if (cmd.rnd_init) round <= '0;
      else if (cmd.rnd_step) round <= round + 6'd1;
      if (cmd.chain_add) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + work[i];
      end
      if (cmd.word_step) word_idx <= word_idx + 3'd1;
      if (cmd.msg_clear) begin
        fill        <= '0;
        length_bits <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= START_H[i];
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (cmd.byte_en) window <= {window[503:0], new_byte};
    else if (cmd.rnd_step) window <= {window[479:0], w_new};

    if (cmd.total_load) total <= length_bits + {55'd0, fill, 3'd0};
    else if (cmd.byte_en && cmd.byte_sel == BSRC_LEN) total <= {total[55:0], 8'h00};

    if (cmd.rnd_init) begin
      for (int i = 0; i < 8; i++) work[i] <= chain[i];
    end else if (cmd.rnd_step) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

  assign status.fill_full  = (fill == LAST_SLOT);
  assign status.fill_len   = (fill == LEN_POS);
  assign status.round_last = (round == LAST_ROUND);
  assign status.word_last  = (word_idx == LAST_WORD);

  assign digest_word = chain[word_idx];
  assign word_index  = word_idx;
  assign last_word   = (word_idx == LAST_WORD);

endmodule

`default_nettype wire

// ----- hdl/ssh_controller.sv -----
// Controller of the SHA-256 stream hasher: sequences byte intake, padding,
// compression and digest output. Uses ssh_pkg.
`default_nettype none

module ssh_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                byte_present,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  input  ssh_pkg::dp_status_t status,
  output ssh_pkg::dp_cmd_t    cmd
);
  import ssh_pkg::*;

  state_t state, state_next;
  state_t ret, ret_next;   // where to go after a compression

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (byte_present && status.fill_full) begin
            state_next = ST_ROUND;
            ret_next   = last_byte ? ST_MARK : ST_IDLE;
          end else if (last_byte) begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        if (status.fill_full) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (status.fill_len) begin
          state_next = ST_LEN;
        end else if (status.fill_full) begin
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end
      end
      ST_LEN: begin
        if (status.fill_full) begin
          state_next = ST_ROUND;
          ret_next   = ST_OUT;
        end
      end
      ST_ROUND: begin
        if (status.round_last) state_next = ST_FOLD;
      end
      ST_FOLD:  state_next = ret;
      ST_OUT: begin
        if (out_ready && status.word_last) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.byte_sel = BSRC_DATA;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && byte_present) begin
          cmd.byte_en = 1'b1;
          if (status.fill_full) begin
            cmd.len_add  = 1'b1;
            cmd.rnd_init = 1'b1;
          end
        end
      end
      ST_MARK: begin
        cmd.byte_en    = 1'b1;
        cmd.byte_sel   = BSRC_MARK;
        cmd.total_load = 1'b1;
        cmd.rnd_init   = status.fill_full;
      end
      ST_ZERO: begin
        if (!status.fill_len) begin
          cmd.byte_en  = 1'b1;
          cmd.byte_sel = BSRC_ZERO;
          cmd.rnd_init = status.fill_full;
        end
      end
      ST_LEN: begin
        cmd.byte_en  = 1'b1;
        cmd.byte_sel = BSRC_LEN;
        cmd.rnd_init = status.fill_full;
      end
      ST_ROUND: cmd.rnd_step  = 1'b1;
      ST_FOLD:  cmd.chain_add = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.word_step = 1'b1;
          cmd.msg_clear = status.word_last;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Depends on ssh_pkg, ssh_stream_if.sv, ssh_controller and ssh_datapath.
// Usage: msg_in carries one transaction per message byte (data_byte valid
//   when byte_present is set). last_byte ends the message; a last transaction
//   with no byte is allowed, so an empty message can be hashed.
//   digest_out then delivers eight transactions, digest word 0 first,
//   word_index 0..7, last_word set on word 7. After word 7 the block is
//   back at the initial hash state for the next message.
// Operation:
//   A byte that does not complete a 64-byte block is shifted straight in. The
//   byte that completes a block starts a compression: a load of the working
//   variables, 64 rounds of the single round unit, then a fold into the
//   chaining words; no new byte is taken until the fold is done.
//   After a last transaction the padding is shifted in byte by byte, and
//   word 0 appears once the final block is compressed, depending on how many
//   bytes it held (an extra block is compressed past 55 bytes).
// msg_in.ready is high only while waiting for a byte; no input is taken
// while a block compresses or the digest is out. Reset (rst, synchronous)
// restores the initial hash values, empty buffer and zero length; a stall
// on digest_out holds the current word steady.
`default_nettype none

module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst,
  ssh_byte_if.sink            msg_in,
  ssh_digest_if.source        digest_out
);
  import ssh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  ssh_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (msg_in.valid),
    .in_ready     (msg_in.ready),
    .byte_present (msg_in.byte_present),
    .last_byte    (msg_in.last_byte),
    .out_valid    (digest_out.valid),
    .out_ready    (digest_out.ready),
    .status       (status),
    .cmd          (cmd)
  );

  ssh_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg_in.data_byte),
    .status      (status),
    .digest_word (digest_out.digest_word),
    .word_index  (digest_out.word_index),
    .last_word   (digest_out.last_word)
  );

endmodule

`default_nettype wire

// ----- hdl/ssh_checker.sv -----
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_defines.svh.
`default_nettype none
`include "sha256_stream_hasher_defines.svh"

module ssh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] digest_word,
  input wire logic [2:0]  word_index,
  input wire logic        last_word
);

  // Input is never taken while a digest is being delivered.
  `SSH_ASSERT_HOLDS(a_no_overlap, !(in_ready && out_valid), "input ready during digest output")

  // A digest burst starts at word 0.
  `SSH_ASSERT_IMPLIES(a_start_word0, $rose(out_valid), word_index == 3'd0, "digest not starting at word 0")

  // Words follow each other without gaps.
  `SSH_ASSERT_NEXT(a_word_seq, out_valid && out_ready && !last_word, out_valid && (word_index == $past(word_index) + 3'd1), "digest word sequence broken")

  // After the last word the block takes input again.
  `SSH_ASSERT_NEXT(a_back_idle, out_valid && out_ready && last_word, in_ready && !out_valid, "not idle after digest")

  // Stalled word holds.
  `SSH_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index), "stalled digest word changed")

endmodule

bind sha256_stream_hasher ssh_checker u_ssh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (msg_in.valid),
  .in_ready    (msg_in.ready),
  .out_valid   (digest_out.valid),
  .out_ready   (digest_out.ready),
  .digest_word (digest_out.digest_word),
  .word_index  (digest_out.word_index),
  .last_word   (digest_out.last_word)
);

`default_nettype wire

// ----- verif/sha256_stream_hasher_tb.sv -----
// Self-checking testbench for sha256_stream_hasher: byte transactions in, digest words out.
// Depends on the interfaces in hdl/ssh_stream_if.sv and the RTL top level.
// A built-in SHA-256 scoreboard predicts every digest word and compares it field by field.
`default_nettype none

module sha256_stream_hasher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: keeps its own hash state, turns accepted byte transactions
  // into expected digest words and compares them with what comes out.
  class digest_scoreboard;
    typedef struct {
      logic [31:0] word;
      logic [2:0]  idx;
      logic        last;
    } digest_word_t;

    localparam bit [31:0] K_TAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] IV_TAB [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    bit [31:0]    chain [8];
    bit [7:0]     blk [64];
    int unsigned  fill;
    bit [63:0]    bit_len;
    digest_word_t expected_words [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = IV_TAB[i];
      fill = 0;
      bit_len = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1;
      bit [31:0] t2;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
               (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      v = chain;
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // One accepted input transaction.
    function void note_transaction(bit [7:0] data, bit present, bit last);
      bit [63:0]    total;
      digest_word_t dw;
      if (present) begin
        blk[fill] = data;
        fill++;
        if (fill == 64) begin
          compress();
          bit_len += 64'd512;
          fill = 0;
        end
      end
      if (!last) return;
      total = bit_len + 64'(fill) * 64'd8;
      blk[fill] = 8'h80;
      fill++;
      // no room for the length field: spill into an extra block
      if (fill > 56) begin
        while (fill < 64) begin blk[fill] = 8'h00; fill++; end
        compress();
        fill = 0;
      end
      while (fill < 56) begin blk[fill] = 8'h00; fill++; end
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = chain[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        expected_words.push_back(dw);
      end
      restart();
    endfunction

    // One accepted digest word.
    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_word_t e;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected digest word %h idx %0d last %b", $realtime, word, idx, last);
        return;
      end
      e = expected_words.pop_front();
      if (word !== e.word || idx !== e.idx || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                   $realtime, e.word, e.idx, e.last, word, idx, last);
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned DRAIN_CYCLES = 300;   // longer than the worst padding latency

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssh_byte_if   msg_in ();
  ssh_digest_if digest_out ();

  digest_scoreboard sb = new();

  int unsigned items_sent = 0;    // transactions that carry a byte or end a message
  int unsigned gapless_left = 0;  // remaining back-to-back transactions in a burst

  sha256_stream_hasher i_dut (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_in),
    .digest_out (digest_out)
  );

  always #4 clk = ~clk;

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("sha256_stream_hasher_tb: errors");
    $finish;
  end

  // Output monitor: every accepted digest word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && digest_out.valid === 1'b1 && digest_out.ready === 1'b1)
      sb.check_word(digest_out.digest_word, digest_out.word_index, digest_out.last_word);
  end

  // Receiver back-pressure. Mix of free-running stretches, long stalls and
  // per-cycle random ready so stalls hit every digest word position.
  initial begin
    int unsigned free_left;
    int unsigned stall_left;
    int unsigned roll;
    free_left = 0;
    stall_left = 0;
    digest_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (free_left != 0) begin
        free_left--;
        digest_out.ready = 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        digest_out.ready = 1'b0;
      end else begin
        roll = $urandom_range(0, 199);
        if (roll < 4) begin
          stall_left = $urandom_range(20, 90);
          digest_out.ready = 1'b0;
        end else if (roll < 10) begin
          free_left = $urandom_range(40, 200);
          digest_out.ready = 1'b1;
        end else begin
          digest_out.ready = ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  // Sender idle cycles before the next transaction: mostly none or short,
  // now and then long, with occasional gapless bursts.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (gapless_left != 0) begin
      gapless_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      gapless_left = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted.
  // valid is left high after acceptance; the next call either replaces the
  // payload at the following falling edge or drops valid for the gap.
  task automatic send_item(input logic [7:0] data, input logic present, input logic last);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      msg_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg_in.data_byte    = data;
    msg_in.byte_present = present;
    msg_in.last_byte    = last;
    msg_in.valid        = 1'b1;
    do @(posedge clk); while (msg_in.ready !== 1'b1);
    sb.note_transaction(data, present, last);
    if (present || last) items_sent++;
  endtask

  // Drop valid and hold off until every predicted digest word has arrived.
  task automatic pause_until_drained();
    @(negedge clk);
    msg_in.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Lengths cluster around the padding boundaries: 55/56 bytes in the last
  // block decide whether an extra block is needed, 64 completes a block.
  function automatic int unsigned pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(0, 12);
    if (roll < 60) return $urandom_range(13, 50);
    if (roll < 75) return $urandom_range(53, 58);
    if (roll < 88) return $urandom_range(61, 66);
    return $urandom_range(117, 122);
  endfunction

  // One message with random content. Occasional empty filler transactions
  // are mixed in; the end mark rides on the last byte or on an empty
  // transaction of its own.
  task automatic send_message(input int unsigned len);
    bit tail_empty;
    tail_empty = (len == 0) || ($urandom_range(0, 1) == 0);
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, !tail_empty && (k == len - 1));
    end
    if (tail_empty)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    msg_in.valid        = 1'b0;
    msg_in.data_byte    = 8'h00;
    msg_in.byte_present = 1'b0;
    msg_in.last_byte    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty message, ignored empty transaction, "abc" with an
    // empty transaction inside, a single byte carrying the end mark,
    // byte extremes followed by an empty end, and 0x80 0x7f ending on its last byte.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item("a", 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b1);
    pause_until_drained();

    // Random messages, sometimes waiting for the digest queue to empty first.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) pause_until_drained();
      send_message(pick_length());
    end
    @(negedge clk);
    msg_in.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    // let any stray digest word show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("sha256_stream_hasher_tb: clean");
    end else begin
      $display("sha256_stream_hasher_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
